[rtl/sacl_pkg.sv]
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative LRU tag store.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int MAX_SETS_DEF = 512;
  localparam int MAX_WAYS_DEF = 8;

  localparam int ADDR_W  = 32;
  localparam int TAG_W   = 32;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int WAY_OUT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd6;
  localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd4;
  localparam logic [CFG_W-1:0] WAYS_IN_USE_RST = 4'd1;

  typedef struct packed {
    logic                 valid;
    logic [TAG_W-1:0]     tag;
    logic [STAMP_W-1:0]   stamp;
  } line_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic capture;
    logic rd;
    logic scan;
    logic wr;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

[rtl/sacl_ctrl.sv]
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: clearing pass, request accept, set read, way scan, write back.
// ----------------------------------------------------------------------------
module sacl_ctrl
  import sacl_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   s_tvalid,
  output logic   s_tready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (sts.out_free) begin
          cmd.wr     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

[rtl/sacl_dp.sv]
// ----------------------------------------------------------------------------
// sacl_dp
// Datapath: config registers, set memory, way scan, counters, result register.
// ----------------------------------------------------------------------------
module sacl_dp
  import sacl_pkg::*;
#(
  parameter int MAX_SETS = MAX_SETS_DEF,
  parameter int MAX_WAYS = MAX_WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [ADDR_W-1:0]     address,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic                  hit,
  output logic [WAY_OUT_W-1:0]  way,
  output logic [CNT_W-1:0]      hit_count,
  output logic [CNT_W-1:0]      miss_count
);

  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int IDX_LIM = $clog2(MAX_SETS + 1) - 1;

  // config registers
  logic [CFG_W-1:0] offset_bits;
  logic [CFG_W-1:0] index_bits;
  logic [CFG_W-1:0] ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_BITS_RST;
      index_bits  <= INDEX_BITS_RST;
      ways_in_use <= WAYS_IN_USE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_OFFSET_BITS: offset_bits <= cfg_data;
        REG_INDEX_BITS:  index_bits  <= cfg_data;
        REG_WAYS_IN_USE: ways_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // address split
  logic [CFG_W-1:0]   ib_sat;
  logic [ADDR_W-1:0]  set_full;
  logic [ADDR_W-1:0]  set_mask;
  logic [TAG_W-1:0]   tag_c;
  logic [4:0]         ways5;
  logic [WAY_W-1:0]   last_way_c;

  always_comb begin
    ib_sat   = (32'(index_bits) > 32'(IDX_LIM)) ? CFG_W'(IDX_LIM) : index_bits;
    set_mask = (32'd1 << ib_sat) - 32'd1;
    set_full = (address >> offset_bits) & set_mask;
    tag_c    = address >> (5'(offset_bits) + 5'(ib_sat));
    ways5    = {1'b0, ways_in_use};
    if (ways5 == 5'd0) begin
      last_way_c = '0;
    end else if (ways5 > 5'(MAX_WAYS)) begin
      last_way_c = WAY_W'(MAX_WAYS - 1);
    end else begin
      last_way_c = WAY_W'(ways5 - 5'd1);
    end
  end

  logic [SET_W-1:0]  set_q;
  logic [TAG_W-1:0]  tag_q;
  logic [WAY_W-1:0]  last_way;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_q    <= set_full[SET_W-1:0];
      tag_q    <= tag_c;
      last_way <= last_way_c;
    end
  end

  // set memory, one row of all ways per set
  line_t [MAX_WAYS-1:0] mem [MAX_SETS];
  line_t [MAX_WAYS-1:0] rd_row;
  line_t [MAX_WAYS-1:0] wr_row;
  logic  [SET_W-1:0]    clr_addr;
  logic  [SET_W-1:0]    wr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + SET_W'(1);
    end
  end

  assign wr_addr = cmd.clr ? clr_addr : set_q;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_row <= mem[set_q];
    end
    if (cmd.wr || cmd.clr) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // way scan
  logic [WAY_W-1:0]    scan_way;
  logic                found;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    victim;
  logic [STAMP_W-1:0]  best;
  line_t               cur;
  logic                hit_now;

  assign cur     = rd_row[scan_way];
  assign hit_now = cur.valid && (cur.tag == tag_q);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      scan_way <= '0;
      found    <= 1'b0;
    end else if (cmd.scan) begin
      scan_way <= scan_way + WAY_W'(1);
      if (hit_now) begin
        found   <= 1'b1;
        hit_way <= scan_way;
      end
      if (scan_way == '0) begin
        best   <= cur.stamp;
        victim <= '0;
      end else if (cur.stamp < best) begin
        best   <= cur.stamp;
        victim <= scan_way;
      end
    end
  end

  // counters and write back
  logic [CNT_W-1:0]   hits;
  logic [CNT_W-1:0]   misses;
  logic [STAMP_W-1:0] total;
  logic [WAY_W-1:0]   pick;
  logic [31:0]        pick_ext;

  assign pick     = found ? hit_way : victim;
  assign pick_ext = 32'(pick);

  always_comb begin
    wr_row = rd_row;
    if (cmd.clr) begin
      wr_row = '0;
    end else begin
      wr_row[pick].stamp = total + 32'd1;
      if (!found) begin
        wr_row[pick].valid = 1'b1;
        wr_row[pick].tag   = tag_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits   <= '0;
      misses <= '0;
      total  <= '0;
    end else if (cmd.wr) begin
      total <= total + 32'd1;
      if (found) begin
        hits <= hits + 32'd1;
      end else begin
        misses <= misses + 32'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.wr) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      hit        <= found;
      way        <= pick_ext[WAY_OUT_W-1:0];
      hit_count  <= found ? hits + 32'd1 : hits;
      miss_count <= found ? misses : misses + 32'd1;
    end
  end

  assign sts.clr_done  = (clr_addr == SET_W'(MAX_SETS - 1));
  assign sts.scan_done = hit_now || (scan_way == last_way);
  assign sts.out_free  = !m_tvalid || m_tready;

  assert property (@(posedge clk) disable iff (rst) (hits + misses) == total)
    else $error("hit and miss counts disagree with access count");

  assert property (@(posedge clk) disable iff (rst) cmd.scan |-> scan_way <= last_way)
    else $error("way scan ran past the last way in use");

  assert property (@(posedge clk) disable iff (rst) cmd.wr |-> (!m_tvalid || m_tready))
    else $error("write back while result register is occupied");

  assert property (@(posedge clk) disable iff (rst) cmd.wr |-> pick <= last_way)
    else $error("picked way outside the ways in use");

endmodule

[rtl/set_assoc_cache_lru_tags_core.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags_core
// Set-associative tag store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one 32-bit byte address. The address is
// split into offset, set index and tag by the offset_bits and index_bits
// registers; the ways of the set are searched for the tag, and on a miss the
// way with the oldest access stamp is refilled. One result per request leaves
// on the master stream: hit flag, way, and running hit and miss counts.
// A request passes through the accept, one set memory read, a scan of the
// ways (up to the hit way, or all ways in use on a miss) on the single shared
// compare unit, and write back, which loads the result register; the next
// request is accepted in the cycle after write back. After reset the block
// runs a clearing pass over every set of the set memory with s_tready low;
// config writes are taken during it.
// A stalled result holds in the output register; a following request is
// still processed up to write back, which waits until the register is free.
// Config writes must go in only while no request is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_tags_core
  import sacl_pkg::*;
#(
  parameter int MAX_SETS = MAX_SETS_DEF,
  parameter int MAX_WAYS = MAX_WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // address[31:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [71:0]           m_tdata    // hit, way[2:0], hit_count[31:0],
                                           // miss_count[31:0], zero pad
);

  cmd_t                  cmd;
  sts_t                  sts;
  logic                  hit;
  logic [WAY_OUT_W-1:0]  way;
  logic [CNT_W-1:0]      hit_count;
  logic [CNT_W-1:0]      miss_count;

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sacl_dp #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .address    (s_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .hit        (hit),
    .way        (way),
    .hit_count  (hit_count),
    .miss_count (miss_count)
  );

  assign m_tdata = {4'b0000, miss_count, hit_count, way, hit};

endmodule

[tb/sv/set_assoc_cache_lru_tags_core_tb.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags_core_tb
// Self-checking bench for the set-associative LRU tag store.
// ----------------------------------------------------------------------------
// A short table of directed requests covers reset state, field extremes and
// the saturating register cases. Random address streams follow, biased to a
// few hot sets so that hits, fills and LRU evictions all occur. A behavioral
// tag store inside the bench computes each expected hit, way and counter
// unless the table row gives it; results are compared field by field. Both
// streams idle at random. Registers change only after all results have drained.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_tags_core_tb;
  import sacl_pkg::*;

  localparam int LINES     = MAX_SETS_DEF * MAX_WAYS_DEF;
  localparam int IDX_LIMIT = $clog2(MAX_SETS_DEF + 1) - 1;
  localparam int PHASES    = 10;
  localparam int PHASE_REQS = 110;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
  } lookup_t;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [CFG_W-1:0] ob;
    logic [CFG_W-1:0] ib;
    logic [CFG_W-1:0] ways;
    logic [31:0]      addr;
    bit               typed;
    lookup_t          res;
  } dir_row_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_OFFSET_BITS;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata = '0;   // address[31:0]
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [71:0]       m_tdata;        // hit, way[2:0], hit_count[31:0],
                                     // miss_count[31:0], zero pad

  // bench copy of the tag store
  bit               line_ok    [LINES];
  bit [TAG_W-1:0]   line_tag   [LINES];
  bit [STAMP_W-1:0] line_stamp [LINES];
  bit [CNT_W-1:0]   hits_tot;
  bit [CNT_W-1:0]   misses_tot;
  logic [CFG_W-1:0] cfg_ob   = OFFSET_BITS_RST;
  logic [CFG_W-1:0] cfg_ib   = INDEX_BITS_RST;
  logic [CFG_W-1:0] cfg_ways = WAYS_IN_USE_RST;

  lookup_t     lookup_q [$];
  dir_row_t    dir_tab  [$];
  int          err_count = 0;
  bit          no_gaps = 1'b0;
  logic [31:0] hot_sets [4];
  logic [31:0] tag_base;

  set_assoc_cache_lru_tags_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned eff_ib();
    return (cfg_ib > IDX_LIMIT) ? IDX_LIMIT : cfg_ib;
  endfunction

  function automatic int unsigned eff_ways();
    if (cfg_ways == 0) return 1;
    return (cfg_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : cfg_ways;
  endfunction

  function automatic lookup_t access_tags(input logic [31:0] addr);
    int unsigned ib, ways, base, pick, w;
    logic [31:0] set_no, tag;
    logic [STAMP_W-1:0] oldest;
    bit found;
    lookup_t r;
    ib = eff_ib();
    ways = eff_ways();
    set_no = (addr >> cfg_ob) & ((32'd1 << ib) - 32'd1);
    tag = addr >> (cfg_ob + ib);
    base = set_no * MAX_WAYS_DEF;
    found = 1'b0;
    pick = 0;
    for (w = 0; w < ways && !found; w++) begin
      if (line_ok[base + w] && line_tag[base + w] == tag) begin
        found = 1'b1;
        pick = w;
      end
    end
    if (found) begin
      hits_tot++;
    end else begin
      // oldest stamp wins, lowest way on ties
      oldest = line_stamp[base];
      for (w = 1; w < ways; w++) begin
        if (line_stamp[base + w] < oldest) begin
          oldest = line_stamp[base + w];
          pick = w;
        end
      end
      misses_tot++;
      line_ok[base + pick] = 1'b1;
      line_tag[base + pick] = tag;
    end
    line_stamp[base + pick] = hits_tot + misses_tot;
    r.hit = found;
    r.way = pick[WAY_OUT_W-1:0];
    r.hits = hits_tot;
    r.misses = misses_tot;
    return r;
  endfunction

  function automatic int idle_len();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] make_addr();
    int unsigned ib, sh;
    logic [31:0] tag, set_no, off;
    if ($urandom_range(0, 9) < 3) return $urandom();
    ib = eff_ib();
    sh = cfg_ob + ib;
    tag = tag_base + $urandom_range(0, eff_ways() + 1);
    set_no = hot_sets[$urandom_range(0, 3)] & ((32'd1 << ib) - 32'd1);
    off = $urandom() & ((32'd1 << cfg_ob) - 32'd1);
    return (tag << sh) | (set_no << cfg_ob) | off;
  endfunction

  function automatic dir_row_t req_row(input logic [31:0] addr);
    return '{kind: ROW_REQ, ob: '0, ib: '0, ways: '0, addr: addr, typed: 1'b0,
             res: '0};
  endfunction

  function automatic dir_row_t chk_row(input logic [31:0] addr, input logic hit,
                                       input logic [2:0] way,
                                       input logic [31:0] hits, misses);
    dir_row_t r;
    r = req_row(addr);
    r.typed = 1'b1;
    r.res = '{hit: hit, way: way, hits: hits, misses: misses};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_W-1:0] ob, ib, ways);
    return '{kind: ROW_CFG, ob: ob, ib: ib, ways: ways, addr: '0, typed: 1'b0,
             res: '0};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] ob, ib, ways);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_OFFSET_BITS;
    cfg_data <= ob;
    @(posedge clk);
    cfg_index <= REG_INDEX_BITS;
    cfg_data <= ib;
    @(posedge clk);
    cfg_index <= REG_WAYS_IN_USE;
    cfg_data <= ways;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_ob = ob;
    cfg_ib = ib;
    cfg_ways = ways;
  endtask

  task automatic send_req(input logic [31:0] addr, input bit typed,
                          input lookup_t typed_res);
    int gap;
    lookup_t pred;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= addr;
    do @(posedge clk); while (!s_tready);
    pred = access_tags(addr);
    lookup_q.push_back(typed ? typed_res : pred);
  endtask

  // result side: check each accepted result, stall at random
  initial begin : result_sink
    int hold;
    lookup_t got, want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.hit = m_tdata[0];
        got.way = m_tdata[3:1];
        got.hits = m_tdata[35:4];
        got.misses = m_tdata[67:36];
        if (lookup_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: %h", m_tdata));
        end else begin
          want = lookup_q.pop_front();
          if (got.hit !== want.hit)
            report_mismatch($sformatf("hit %b want %b", got.hit, want.hit));
          if (got.way !== want.way)
            report_mismatch($sformatf("way %0d want %0d", got.way, want.way));
          if (got.hits !== want.hits)
            report_mismatch($sformatf("hit_count %0d want %0d", got.hits, want.hits));
          if (got.misses !== want.misses)
            report_mismatch($sformatf("miss_count %0d want %0d", got.misses,
                                      want.misses));
        end
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        hold = idle_len();
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    int phase, n;
    // reset settings: 64-byte blocks, 16 sets, one way
    dir_tab.push_back(chk_row(32'h0000_0000, 1'b0, 3'd0, 32'd0, 32'd1));
    dir_tab.push_back(chk_row(32'h0000_003f, 1'b1, 3'd0, 32'd1, 32'd1));
    dir_tab.push_back(chk_row(32'hffff_ffff, 1'b0, 3'd0, 32'd1, 32'd2));
    dir_tab.push_back(chk_row(32'h0000_0400, 1'b0, 3'd0, 32'd1, 32'd3));
    dir_tab.push_back(chk_row(32'h0000_0000, 1'b0, 3'd0, 32'd1, 32'd4));
    // all eight ways, fill then hit
    dir_tab.push_back(cfg_row(4'd6, 4'd4, 4'd8));
    dir_tab.push_back(req_row(32'h0000_0400));
    dir_tab.push_back(req_row(32'h0000_0800));
    dir_tab.push_back(req_row(32'h0000_0c00));
    dir_tab.push_back(req_row(32'h0000_0400));
    // zero ways acts as one
    dir_tab.push_back(cfg_row(4'd6, 4'd4, 4'd0));
    dir_tab.push_back(req_row(32'h0000_0800));
    // largest register values: offset as written, index and ways saturate
    dir_tab.push_back(cfg_row(4'd15, 4'd15, 4'd15));
    dir_tab.push_back(req_row(32'hffff_ffff));
    dir_tab.push_back(req_row(32'h0000_7fff));
    dir_tab.push_back(req_row(32'h00ff_8000));
    dir_tab.push_back(req_row(32'hffff_0000));
    // no offset, no index
    dir_tab.push_back(cfg_row(4'd0, 4'd0, 4'd1));
    dir_tab.push_back(req_row(32'h0000_0001));
    dir_tab.push_back(req_row(32'h0000_0001));
    dir_tab.push_back(req_row(32'hffff_fffe));
    dir_tab.push_back(cfg_row(4'd12, 4'd9, 4'd8));
    dir_tab.push_back(req_row(32'h8000_0000));
    dir_tab.push_back(req_row(32'h0000_1000));
    dir_tab.push_back(req_row(32'h8000_0fff));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == ROW_CFG)
        set_config(row.ob, row.ib, row.ways);
      else
        send_req(row.addr, row.typed, row.res);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_config(4'd0, 4'd0, 4'd1);
        1: set_config(4'd15, 4'd15, 4'd15);
        2: set_config(4'd12, 4'd9, 4'd8);
        3: set_config(4'd0, 4'd9, 4'd0);
        4: set_config(4'd6, 4'd4, 4'd1);
        default: set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                            4'($urandom_range(0, 15)));
      endcase
      foreach (hot_sets[k]) hot_sets[k] = $urandom();
      tag_base = $urandom();
      no_gaps = (phase % 4 == 2);
      for (n = 0; n < PHASE_REQS; n++) begin
        // mid-phase drain with the sender held off
        if (n == PHASE_REQS / 2 && phase == 5) wait_drained();
        send_req(make_addr(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (err_count == 0 && lookup_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sacl_pkg.sv
rtl/sacl_ctrl.sv
rtl/sacl_dp.sv
rtl/set_assoc_cache_lru_tags_core.sv
tb/sv/set_assoc_cache_lru_tags_core_tb.sv
